// File: rtl/lmrs_pkg.sv
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types and constants for the led matrix row scan driver.
// ----------------------------------------------------------------------------
package lmrs_pkg;

    localparam int unsigned ROWS        = 8;
    localparam int unsigned WORD_BITS   = 16;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [7:0]  BAR_COLUMNS = 8'hAA;

    typedef enum logic [2:0] {
        REQ_SET_PIXEL   = 3'd0,
        REQ_CLEAR_FRAME = 3'd1,
        REQ_WRITE_ROW   = 3'd2,
        REQ_REFRESH     = 3'd3,
        REQ_LEVEL_BARS  = 3'd4
    } req_type_t;

    typedef enum logic [2:0] {
        OP_SET_BIT,
        OP_CLEAR_BIT,
        OP_CLEAR_FRAME,
        OP_WRITE_ROW,
        OP_REFRESH,
        OP_BARS
    } op_t;

    // data: column mask for bit edits, row pixels for row writes, row mask for bars
    typedef struct packed {
        op_t        op;
        logic [2:0] row;
        logic [7:0] data;
    } cmd_t;

endpackage

// File: rtl/lmrs_front.sv
// ----------------------------------------------------------------------------
// lmrs_front
// Request decoder: classifies each known request into a queue command; unused codes are not pushed.
// ----------------------------------------------------------------------------
module lmrs_front
    import lmrs_pkg::*;
(
    input  logic       start,
    input  logic       full,
    input  logic [2:0] req_type,
    input  logic [2:0] row,
    input  logic [2:0] column,
    input  logic       pixel_on,
    input  logic [7:0] row_bits,
    input  logic [7:0] level,
    output logic       push,
    output cmd_t       cmd
);

    logic       known;
    logic [7:0] bar_rows;

    // bottom (level mod 8)+1 rows lit
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            bar_rows[r] = (3'(r) >= ~level[2:0]);
        end
    end

    always_comb
    begin
        known    = 1'b1;
        cmd.op   = OP_REFRESH;
        cmd.row  = row;
        cmd.data = row_bits;
        unique case (req_type)
            REQ_SET_PIXEL:
            begin
                cmd.op   = pixel_on ? OP_SET_BIT : OP_CLEAR_BIT;
                cmd.data = 8'd1 << column;
            end
            REQ_CLEAR_FRAME: cmd.op = OP_CLEAR_FRAME;
            REQ_WRITE_ROW:   cmd.op = OP_WRITE_ROW;
            REQ_REFRESH:     cmd.op = OP_REFRESH;
            REQ_LEVEL_BARS:
            begin
                cmd.op   = OP_BARS;
                cmd.data = bar_rows;
            end
            default:         known = 1'b0;
        endcase
    end

    assign push = start && !full && known;

endmodule

// File: rtl/lmrs_fifo.sv
// ----------------------------------------------------------------------------
// lmrs_fifo
// Short command queue between the decoder and the frame engine.
// ----------------------------------------------------------------------------
module lmrs_fifo
    import lmrs_pkg::*;
#(
    parameter int unsigned Width = 14,
    parameter int unsigned Depth = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [Width-1:0] wr_data,
    input  logic             pop,
    output logic [Width-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    logic [Width-1:0] mem_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CntW'(Depth));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !push) |=> empty)
        else $error("queue filled without a push");

endmodule

// File: rtl/lmrs_back.sv
// ----------------------------------------------------------------------------
// lmrs_back
// Frame engine: holds the 8x8 frame and scan row, applies edits and
// shifts out refresh words one bit per clock.
// ----------------------------------------------------------------------------
module lmrs_back
    import lmrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       empty,
    output logic       pop,
    output logic       strobe,
    output logic       serial_bit,
    output logic [3:0] bit_position,
    output logic       latch
);

    localparam int unsigned CntW = $clog2(WORD_BITS);

    logic [7:0]           frame_reg [ROWS];
    logic [7:0]           frame_next [ROWS];
    logic [2:0]           scan_row_reg, scan_row_next;
    logic                 active_reg, active_next;
    logic [CntW-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [WORD_BITS-1:0] word_reg, word_next;

    assign pop = !empty && (!active_reg || bit_cnt_reg == '0);

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            frame_next[r] = frame_reg[r];
            if (pop)
            begin
                unique case (cmd.op)
                    OP_SET_BIT:
                    begin
                        if (cmd.row == 3'(r))
                        begin
                            frame_next[r] = frame_reg[r] | cmd.data;
                        end
                    end
                    OP_CLEAR_BIT:
                    begin
                        if (cmd.row == 3'(r))
                        begin
                            frame_next[r] = frame_reg[r] & ~cmd.data;
                        end
                    end
                    OP_CLEAR_FRAME: frame_next[r] = '0;
                    OP_WRITE_ROW:
                    begin
                        if (cmd.row == 3'(r))
                        begin
                            frame_next[r] = cmd.data;
                        end
                    end
                    OP_BARS:        frame_next[r] = cmd.data[r] ? BAR_COLUMNS : 8'd0;
                    default:        frame_next[r] = frame_reg[r];
                endcase
            end
        end
    end

    always_comb
    begin
        active_next   = active_reg;
        bit_cnt_next  = bit_cnt_reg;
        word_next     = word_reg;
        scan_row_next = scan_row_reg;
        if (active_reg)
        begin
            word_next    = word_reg << 1;
            bit_cnt_next = bit_cnt_reg - 1'b1;
            if (bit_cnt_reg == '0)
            begin
                active_next = 1'b0;
            end
        end
        if (pop && cmd.op == OP_REFRESH)
        begin
            word_next     = {frame_reg[scan_row_reg], 8'd1 << scan_row_reg};
            bit_cnt_next  = CntW'(WORD_BITS - 1);
            active_next   = 1'b1;
            scan_row_next = scan_row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                frame_reg[r] <= '0;
            end
            scan_row_reg <= '0;
            active_reg   <= 1'b0;
            bit_cnt_reg  <= '0;
            word_reg     <= '0;
        end
        else
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                frame_reg[r] <= frame_next[r];
            end
            scan_row_reg <= scan_row_next;
            active_reg   <= active_next;
            bit_cnt_reg  <= bit_cnt_next;
            word_reg     <= word_next;
        end
    end

    assign strobe       = active_reg;
    assign serial_bit   = word_reg[WORD_BITS-1];
    assign bit_position = bit_cnt_reg;
    assign latch        = active_reg && (bit_cnt_reg == '0);

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && bit_position != 4'd0) |=>
            (strobe && bit_position == $past(bit_position) - 4'd1))
        else $error("refresh word cut short");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(strobe) |-> bit_position == CntW'(WORD_BITS - 1))
        else $error("refresh word not started at top bit");

endmodule

// File: rtl/led_matrix_row_scan_driver_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_row_scan_driver_unit
// Row-scanned 8x8 led matrix driver feeding a 16-bit shift register chain.
// ----------------------------------------------------------------------------
// refresh start: a refresh request accepted while the frame engine is idle passes through the command
//   queue and is then loaded into the shift word register, which drives its first bit
// throughput: frame edits retire one per clock while no refresh is shifting; a
//   refresh holds the frame engine until its last bit, one bit per clock, and the next command is popped with that bit
// busy rises when the command queue is full; the receiver cannot stall
// reset clears the frame, the scan row and the queue at once
module led_matrix_row_scan_driver_unit
    import lmrs_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] req_type,
    input  logic [2:0] row,
    input  logic [2:0] column,
    input  logic       pixel_on,
    input  logic [7:0] row_bits,
    input  logic [7:0] level,
    output logic       strobe,
    output logic       serial_bit,
    output logic [3:0] bit_position,
    output logic       latch
);

    cmd_t wr_cmd;
    cmd_t rd_cmd;
    logic push;
    logic pop;
    logic empty;
    logic full;

    assign busy = full;

    lmrs_front u_front (
        .start    (start),
        .full     (full),
        .req_type (req_type),
        .row      (row),
        .column   (column),
        .pixel_on (pixel_on),
        .row_bits (row_bits),
        .level    (level),
        .push     (push),
        .cmd      (wr_cmd)
    );

    lmrs_fifo #(
        .Width ($bits(cmd_t)),
        .Depth (QueueDepth)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_cmd),
        .pop     (pop),
        .rd_data (rd_cmd),
        .empty   (empty),
        .full    (full)
    );

    lmrs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (rd_cmd),
        .empty        (empty),
        .pop          (pop),
        .strobe       (strobe),
        .serial_bit   (serial_bit),
        .bit_position (bit_position),
        .latch        (latch)
    );

endmodule

// File: bench/tb_led_matrix_row_scan_driver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_row_scan_driver_unit
// Self-checking bench for the led matrix row scan driver. Frame edits, level
// bars, unused codes and refresh ticks are issued by a queue-fed driver with
// random idle gaps and several full drain pauses. A local model of the frame store
// and scan row predicts every shifted bit, and the monitor checks each
// strobed bit in order against that prediction.
// ----------------------------------------------------------------------------
module tb_led_matrix_row_scan_driver_unit;
    import lmrs_pkg::*;

    localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;
    localparam int         RANDOM_REQUESTS    = 350;
    localparam int         CYCLE_LIMIT        = 200000;
    localparam int         TAIL_CYCLES        = 40;

    typedef struct {
        logic [2:0] req_type;
        logic [2:0] row;
        logic [2:0] column;
        logic       pixel_on;
        logic [7:0] row_bits;
        logic [7:0] level;
        int         gap;
        bit         drain;
    } scan_req_t;

    typedef struct packed {
        logic       serial_bit;
        logic [3:0] bit_position;
        logic       latch;
    } shift_bit_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [2:0] req_type;
    logic [2:0] row;
    logic [2:0] column;
    logic       pixel_on;
    logic [7:0] row_bits;
    logic [7:0] level;
    logic       strobe;
    logic       serial_bit;
    logic [3:0] bit_position;
    logic       latch;

    scan_req_t  pending_reqs[$];
    shift_bit_t expected_bits[$];
    scan_req_t  next_req;
    logic [7:0] frame_model[ROWS];
    logic [2:0] scan_row_model;
    int         issued_count;
    int         accepted_count;
    int         idle_count;
    int         cycle_count;
    int         error_count;

    led_matrix_row_scan_driver_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .row          (row),
        .column       (column),
        .pixel_on     (pixel_on),
        .row_bits     (row_bits),
        .level        (level),
        .strobe       (strobe),
        .serial_bit   (serial_bit),
        .bit_position (bit_position),
        .latch        (latch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic scan_req_t make_req(input logic [2:0] kind, input logic [2:0] r,
                                           input logic [2:0] c, input logic on,
                                           input logic [7:0] bits, input logic [7:0] lvl);
        scan_req_t req;
        req.req_type = kind;
        req.row      = r;
        req.column   = c;
        req.pixel_on = on;
        req.row_bits = bits;
        req.level    = lvl;
        req.gap      = 0;
        req.drain    = 1'b0;
        return req;
    endfunction

    task automatic predict_request(input logic [2:0] kind, input logic [2:0] r,
                                   input logic [2:0] c, input logic on,
                                   input logic [7:0] bits, input logic [7:0] lvl);
        logic [15:0] word;
        shift_bit_t  sb;
        int          pos;
        case (kind)
            REQ_SET_PIXEL:
            begin
                frame_model[r][c] = on;
            end
            REQ_CLEAR_FRAME:
            begin
                for (int i = 0; i < ROWS; i++)
                    frame_model[i] = 8'h00;
            end
            REQ_WRITE_ROW:
            begin
                frame_model[r] = bits;
            end
            REQ_REFRESH:
            begin
                word = {frame_model[scan_row_model], 8'(1 << scan_row_model)};
                for (int k = 0; k < WORD_BITS; k++)
                begin
                    pos             = WORD_BITS - 1 - k;
                    sb.serial_bit   = word[pos];
                    sb.bit_position = 4'(pos);
                    sb.latch        = (k == WORD_BITS - 1);
                    expected_bits.push_back(sb);
                end
                scan_row_model = scan_row_model + 3'd1;
            end
            REQ_LEVEL_BARS:
            begin
                for (int i = 0; i < ROWS; i++)
                    frame_model[i] = (i >= 7 - int'(lvl[2:0])) ? BAR_COLUMNS : 8'h00;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: mismatch on %s, got %0d expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // driver: present the next request once the previous one has been taken
    always @(negedge clk)
    begin
        if (rst_n && !(start && accepted_count != issued_count))
        begin
            if (pending_reqs.size() == 0)
                start <= 1'b0;
            else if (pending_reqs[0].drain && expected_bits.size() != 0)
                start <= 1'b0;
            else if (idle_count < pending_reqs[0].gap)
            begin
                start      <= 1'b0;
                idle_count <= idle_count + 1;
            end
            else
            begin
                next_req      = pending_reqs.pop_front();
                req_type     <= next_req.req_type;
                row          <= next_req.row;
                column       <= next_req.column;
                pixel_on     <= next_req.pixel_on;
                row_bits     <= next_req.row_bits;
                level        <= next_req.level;
                start        <= 1'b1;
                idle_count   <= 0;
                issued_count <= issued_count + 1;
            end
        end
    end

    // monitor: check strobed bits, predict on each accepted request
    always @(posedge clk)
    begin
        shift_bit_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            if (rst_n && strobe === 1'b1)
            begin
                if (expected_bits.size() == 0)
                    report_mismatch("strobe with nothing pending", 1, 0);
                else
                begin
                    want = expected_bits.pop_front();
                    if (serial_bit !== want.serial_bit)
                        report_mismatch("serial_bit", serial_bit, want.serial_bit);
                    if (bit_position !== want.bit_position)
                        report_mismatch("bit_position", bit_position, want.bit_position);
                    if (latch !== want.latch)
                        report_mismatch("latch", latch, want.latch);
                end
            end
            if (rst_n && start && busy === 1'b0)
            begin
                predict_request(req_type, row, column, pixel_on, row_bits, level);
                accepted_count <= accepted_count + 1;
            end
        end
    end

    initial
    begin
        scan_req_t req;
        int        valid_count;
        int        roll;
        int        phase;

        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = REQ_SET_PIXEL;
        row            = 3'd0;
        column         = 3'd0;
        pixel_on       = 1'b0;
        row_bits       = 8'h00;
        level          = 8'h00;
        issued_count   = 0;
        accepted_count = 0;
        idle_count     = 0;
        cycle_count    = 0;
        error_count    = 0;
        scan_row_model = 3'd0;
        for (int i = 0; i < ROWS; i++)
            frame_model[i] = 8'h00;

        // directed: corner pixels, full rows, bars at the extremes, unused codes,
        // refreshes over all rows and the wrap back to row zero
        pending_reqs.push_back(make_req(REQ_SET_PIXEL, 3'd0, 3'd0, 1'b1, 8'h00, 8'h00));
        pending_reqs.push_back(make_req(REQ_SET_PIXEL, 3'd7, 3'd7, 1'b1, 8'hFF, 8'hFF));
        pending_reqs.push_back(make_req(REQ_SET_PIXEL, 3'd7, 3'd7, 1'b0, 8'h00, 8'h00));
        pending_reqs.push_back(make_req(REQ_REFRESH, 3'd0, 3'd0, 1'b0, 8'h00, 8'h00));
        pending_reqs.push_back(make_req(REQ_WRITE_ROW, 3'd1, 3'd0, 1'b0, 8'hFF, 8'h00));
        pending_reqs.push_back(make_req(REQ_REFRESH, 3'd7, 3'd7, 1'b1, 8'hFF, 8'hFF));
        pending_reqs.push_back(make_req(REQ_WRITE_ROW, 3'd2, 3'd3, 1'b1, 8'h5A, 8'h00));
        pending_reqs.push_back(make_req(REQ_REFRESH, 3'd0, 3'd0, 1'b0, 8'h00, 8'h00));
        pending_reqs.push_back(make_req(REQ_LEVEL_BARS, 3'd0, 3'd0, 1'b0, 8'h00, 8'h00));
        pending_reqs.push_back(make_req(REQ_REFRESH, 3'd0, 3'd0, 1'b0, 8'h00, 8'h00));
        for (int k = REQ_RESERVED_FIRST; k <= REQ_RESERVED_LAST; k++)
            pending_reqs.push_back(make_req(3'(k), 3'd7, 3'd7, 1'b1, 8'hFF, 8'hFF));
        pending_reqs.push_back(make_req(REQ_REFRESH, 3'd0, 3'd0, 1'b0, 8'h00, 8'h00));
        pending_reqs.push_back(make_req(REQ_LEVEL_BARS, 3'd0, 3'd0, 1'b0, 8'h00, 8'hFF));
        for (int k = 0; k < 4; k++)
            pending_reqs.push_back(make_req(REQ_REFRESH, 3'd0, 3'd0, 1'b0, 8'h00, 8'h00));
        req = make_req(REQ_CLEAR_FRAME, 3'd0, 3'd0, 1'b0, 8'h00, 8'h00);
        req.drain = 1'b1;
        pending_reqs.push_back(req);
        pending_reqs.push_back(make_req(REQ_REFRESH, 3'd0, 3'd0, 1'b0, 8'h00, 8'h00));
        req = make_req(REQ_LEVEL_BARS, 3'd0, 3'd0, 1'b0, 8'h00, 8'h08);
        req.gap = 5;
        pending_reqs.push_back(req);
        pending_reqs.push_back(make_req(REQ_WRITE_ROW, 3'd7, 3'd0, 1'b0, 8'h00, 8'h00));
        pending_reqs.push_back(make_req(REQ_REFRESH, 3'd0, 3'd0, 1'b0, 8'h00, 8'h00));

        valid_count = 0;
        while (valid_count < RANDOM_REQUESTS)
        begin
            req = make_req(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                           3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            roll = $urandom_range(0, 99);
            if (roll < 32)
                req.req_type = REQ_REFRESH;
            else if (roll < 56)
                req.req_type = REQ_SET_PIXEL;
            else if (roll < 71)
                req.req_type = REQ_WRITE_ROW;
            else if (roll < 77)
                req.req_type = REQ_CLEAR_FRAME;
            else if (roll < 90)
                req.req_type = REQ_LEVEL_BARS;
            else if (roll < 95)
                req.req_type = 3'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
            phase = (valid_count / 40) % 3;
            if (phase != 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    req.gap = 0;
                else if (roll < 90)
                    req.gap = $urandom_range(1, 3);
                else
                    req.gap = $urandom_range(12, 48);
            end
            req.drain = (valid_count == 120) || (valid_count == 260);
            pending_reqs.push_back(req);
            if (req.req_type < REQ_RESERVED_FIRST)
                valid_count++;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || accepted_count != issued_count)
            @(posedge clk);
        while (expected_bits.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/lmrs_pkg.sv
rtl/lmrs_front.sv
rtl/lmrs_fifo.sv
rtl/lmrs_back.sv
rtl/led_matrix_row_scan_driver_unit.sv
bench/tb_led_matrix_row_scan_driver_unit.sv
